// File: hw/rtl/hmsf_pkg.sv
// Shared types, register map and prefix tables of the HTTP message start finder.
// No dependencies; every other file imports this package.
package hmsf_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int START_BITS            = 17;
    localparam int HIST_DEPTH            = 8;
    localparam int PFX_MAX_LEN           = 9;
    localparam int PFX_COUNT             = 11;
    localparam int PFX_REQ_COUNT         = 9;

    // register map, index = paddr[2]
    localparam logic REG_MESSAGE_KIND = 1'b0;
    localparam logic REG_BASE_OFFSET  = 1'b1;

    localparam logic [1:0] KIND_REQUEST  = 2'd0;
    localparam logic [1:0] KIND_RESPONSE = 2'd1;

    typedef logic [PFX_MAX_LEN-1:0][7:0] pfx_text_t;
    typedef logic [HIST_DEPTH-1:0][7:0]  hist_t;

    // Right-aligned text: byte 0 is the last character of the prefix.
    localparam pfx_text_t PFX_TEXT [PFX_COUNT] = '{
        "GET ", "HEAD ", "POST ", "PUT ", "DELETE ", "CONNECT ",
        "OPTIONS ", "TRACE ", "PATCH ", "HTTP/1.1 ", "HTTP/1.0 "
    };
    localparam logic [3:0] PFX_LEN [PFX_COUNT] = '{
        4'd4, 4'd5, 4'd5, 4'd4, 4'd7, 4'd8, 4'd8, 4'd6, 4'd6, 4'd9, 4'd9
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic                  found;
        logic [START_BITS-1:0] start_position;
        logic                  too_long;
    } out_word_t;

    typedef struct packed {
        logic [1:0]  message_kind;
        logic [15:0] base_offset;
    } cfg_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] back;
    } match_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } res_t;

endpackage

// File: hw/rtl/hmsf_apb_regs.sv
// APB configuration registers: message kind and base offset.
// Depends on hmsf_pkg.
module hmsf_apb_regs
    import hmsf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [1:0]  kind_reg;
    logic [15:0] base_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_REQUEST;
            base_reg <= '0;
        end else if (wr_en) begin
            // byte-lane bits of paddr are ignored
            case (paddr[2])
                REG_MESSAGE_KIND: kind_reg <= pwdata[1:0];
                REG_BASE_OFFSET:  base_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MESSAGE_KIND: prdata = {30'd0, kind_reg};
            REG_BASE_OFFSET:  prdata = {16'd0, base_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.message_kind = kind_reg;
    assign cfg.base_offset  = base_reg;

endmodule

// File: hw/rtl/hmsf_prefix_match.sv
// Parallel compare of the current byte and the byte history against the
// method / version prefix table. Depends on hmsf_pkg.
module hmsf_prefix_match
    import hmsf_pkg::*;
(
    input  logic [7:0] cur_byte,
    input  hist_t      hist,
    input  logic [1:0] message_kind,
    output match_t     match
);

    logic [HIST_DEPTH:0][7:0] win;
    logic [PFX_COUNT-1:0]     hit;

    assign win = {hist, cur_byte};

    always_comb begin
        match.back = '0;
        for (int p = 0; p < PFX_COUNT; p++) begin
            hit[p] = (p < PFX_REQ_COUNT) ? (message_kind == KIND_REQUEST)
                                         : (message_kind == KIND_RESPONSE);
            for (int i = 0; i < PFX_MAX_LEN; i++) begin
                if ((4'(i) < PFX_LEN[p]) && (win[i] != PFX_TEXT[p][i])) begin
                    hit[p] = 1'b0;
                end
            end
            // no prefix is a suffix of another, so at most one hits
            if (hit[p]) begin
                match.back = match.back | (PFX_LEN[p] - 4'd1);
            end
        end
        match.hit = |hit;
    end

endmodule

// File: hw/rtl/hmsf_search.sv
// Search state: history, terminator tracking, candidate and position counter.
// Depends on hmsf_pkg and hmsf_prefix_match.
module hmsf_search
    import hmsf_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  in_word_t in_word,
    input  cfg_t     cfg,
    output res_t     res
);

    localparam logic [1:0] TERM_IDLE   = 2'd0;
    localparam logic [1:0] TERM_CR     = 2'd1;
    localparam logic [1:0] TERM_CRLF   = 2'd2;
    localparam logic [1:0] TERM_CRLFCR = 2'd3;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    hist_t                    hist_reg,  hist_next,  hist_eff;
    logic [1:0]               term_reg,  term_next,  term_eff;
    logic                     cv_reg,    cv_next,    cv_eff;
    logic [POSITION_BITS-1:0] cp_reg,    cp_next,    cp_eff;
    logic [POSITION_BITS-1:0] count_reg, count_next, count_eff;
    logic                     done_reg,  done_next,  done_eff;
    logic                     ovf_reg,   ovf_next,   ovf_eff;

    match_t                                match;
    logic [POSITION_BITS-1:0]              back_ext;
    logic [POSITION_BITS-1:0]              st;
    logic [POSITION_BITS+START_BITS-1:0]   cand_ext;
    logic [START_BITS-1:0]                 found_pos;
    logic                                  complete;

    assign hist_eff  = in_word.first_byte ? '0 : hist_reg;
    assign term_eff  = in_word.first_byte ? TERM_IDLE : term_reg;
    assign cv_eff    = in_word.first_byte ? 1'b0 : cv_reg;
    assign cp_eff    = in_word.first_byte ? '0 : cp_reg;
    assign count_eff = in_word.first_byte ? '0 : count_reg;
    assign done_eff  = in_word.first_byte ? 1'b0 : done_reg;
    assign ovf_eff   = in_word.first_byte ? 1'b0 : ovf_reg;

    hmsf_prefix_match u_match (
        .cur_byte     (in_word.data_byte),
        .hist         (hist_eff),
        .message_kind (cfg.message_kind),
        .match        (match)
    );

    assign back_ext = POSITION_BITS'(match.back);
    assign st       = (count_eff >= back_ext) ? count_eff - back_ext : '0;

    // a found result is only possible on LF, where no prefix can end,
    // so the stored candidate is the one to report
    assign cand_ext  = (POSITION_BITS + START_BITS)'(cp_reg);
    assign found_pos = START_BITS'(cfg.base_offset) + cand_ext[START_BITS-1:0];

    always_comb begin
        hist_next  = hist_eff;
        term_next  = term_eff;
        cv_next    = cv_eff;
        cp_next    = cp_eff;
        count_next = count_eff;
        done_next  = done_eff;
        ovf_next   = ovf_eff;
        complete   = 1'b0;
        res        = '0;

        if (!done_eff) begin
            // saturating position counter
            if (&count_eff) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_eff + 1'b1;
            end

            if (match.hit && (!cv_eff || st > cp_eff)) begin
                cp_next = st;
                cv_next = 1'b1;
            end

            if (in_word.data_byte == CHAR_CR) begin
                term_next = (term_eff == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
            end else if (in_word.data_byte == CHAR_LF) begin
                case (term_eff)
                    TERM_CR:     term_next = TERM_CRLF;
                    TERM_CRLFCR: begin
                        term_next = TERM_IDLE;
                        complete  = 1'b1;
                    end
                    default:     term_next = TERM_IDLE;
                endcase
            end else begin
                term_next = TERM_IDLE;
            end

            if (complete) begin
                if (cv_eff) begin
                    res.valid               = 1'b1;
                    res.word.found          = 1'b1;
                    res.word.start_position = found_pos;
                    res.word.too_long       = ovf_next;
                    done_next               = 1'b1;
                end else begin
                    cp_next = '0;
                end
            end

            hist_next = {hist_eff[HIST_DEPTH-2:0], in_word.data_byte};

            if (in_word.last_byte) begin
                if (!res.valid) begin
                    res.valid         = 1'b1;
                    res.word.found    = 1'b0;
                    res.word.too_long = ovf_next;
                end
                done_next = 1'b1;
            end
        end

        if (!step) begin
            res.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg  <= '0;
            term_reg  <= TERM_IDLE;
            cv_reg    <= 1'b0;
            cp_reg    <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else if (step) begin
            hist_reg  <= hist_next;
            term_reg  <= term_next;
            cv_reg    <= cv_next;
            cp_reg    <= cp_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    // a finished search stays silent until the next first-byte mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && done_reg && !in_word.first_byte |-> !res.valid)
        else $error("result emitted after search done");

    // every result ends the search
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> done_reg)
        else $error("search not marked done after a result");
`endif

endmodule

// File: hw/rtl/http_message_start_finder.sv
// HTTP message start finder, top level: input register, search stage,
// result register and APB configuration port.
// Depends on hmsf_pkg, hmsf_apb_regs, hmsf_search.
//
// Usage: bytes of a buffer enter on the s_ channel, one word per byte.
// first_byte on a word clears all search state and makes that byte
// relative position 0; last_byte marks the end of the buffer. The m_
// channel gives at most one word per buffer: found with base_offset plus
// the start position of the latest method (request kind) or version
// (response kind) prefix before the first CRLFCRLF, or not-found at the
// last byte. too_long flags that the position counter saturated.
// Throughput: one byte per cycle while the result register is free or
// m_ready is high; the single history compare and the terminator tracker
// settle combinationally between the input register and the result
// register. When m_ready is low the result register holds its word and
// the input register holds one byte, with s_ready low. Reset clears all
// search state, message_kind to request and base_offset to zero. Write the
// registers only while the block is idle.
module http_message_start_finder
    import hmsf_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t      cfg;
    res_t      res;
    logic      in_valid_reg, in_valid_next;
    in_word_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg;
    logic      advance;

    hmsf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hmsf_search #(
        .POSITION_BITS (POSITION_BITS)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .in_word (in_data_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // the held byte moves on whenever the result register can take a word
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (res.valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (res.valid) begin
            out_data_reg <= res.word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    // a held byte waits unchanged while the result side is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("held input word lost or changed");

    // a new result never overwrites one that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !out_valid_reg || m_ready)
        else $error("result register overrun");
`endif

endmodule
